// File: rtl/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared widths, codes and default parameters of the region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int SIZE_W = 13;
  localparam int OFF_W  = 12;

  localparam int DEF_PAGE_BYTES  = 4096;
  localparam int DEF_GRAIN       = 8;
  localparam int DEF_MAX_REGIONS = 512;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SIZE   = 2'd1,
    ST_NO_SPACE   = 2'd2,
    ST_BAD_OFFSET = 2'd3
  } status_e;

endpackage

// File: rtl/ffra_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_cmd_if / ffra_rsp_if
// Valid/ready channels carrying allocator commands and responses.
// ----------------------------------------------------------------------------
interface ffra_cmd_if;
  import ffra_pkg::*;
  logic                valid;
  logic                ready;
  cmd_e                cmd;
  logic [SIZE_W-1:0]   req_size;
  logic [OFF_W-1:0]    region_offset;

  modport source (output valid, cmd, req_size, region_offset, input ready);
  modport sink   (input valid, cmd, req_size, region_offset, output ready);
endinterface

interface ffra_rsp_if;
  import ffra_pkg::*;
  logic                valid;
  logic                ready;
  status_e             status;
  logic [OFF_W-1:0]    grant_offset;

  modport source (output valid, status, grant_offset, input ready);
  modport sink   (input valid, status, grant_offset, output ready);
endinterface

// File: rtl/first_fit_region_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// First-fit heap allocator with an address-ordered free table and coalescing.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | transaction
//  req_i   | in  | cmd, req_size, region_offset     | valid & ready
//  rsp_o   | out | status, grant_offset             | valid & ready
//
//  One command at a time through a sequencer over the two table memories.
//  Allocate: a grain check, then a read and a compare per free entry
//  scanned, plus a read and a write per entry moved when a region leaves the table.
//  Free: a read and a compare per allocated entry scanned and per free entry
//  scanned, plus a read and a write per free entry moved on insert or merge-remove.
//  Reset is immediate; no clearing pass. A waiting response blocks new input.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_core #(
  parameter int PAGE_BYTES  = ffra_pkg::DEF_PAGE_BYTES,
  parameter int GRAIN       = ffra_pkg::DEF_GRAIN,
  parameter int MAX_REGIONS = ffra_pkg::DEF_MAX_REGIONS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffra_cmd_if.sink   req_i,
  ffra_rsp_if.source rsp_o
);
  import ffra_pkg::*;

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int SW = $clog2(PAGE_BYTES);
  localparam int LW = $clog2(PAGE_BYTES + 1);
  localparam int XW = (LW > SIZE_W) ? LW : SIZE_W;
  localparam int EW = XW + 1;
  localparam int DW = SW + LW;
  localparam int RS = SIZE_W + 7;
  localparam int RW = RS + 1;
  localparam int PW = SIZE_W + RW;
  localparam logic [RW-1:0] RECIP = RW'((1 << RS) / GRAIN + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_CHK, S_A_RD, S_A_CMP, S_RM_RD, S_RM_WR,
    S_U_RD, S_U_CMP, S_U_MV, S_P_RD, S_P_CMP, S_JOIN, S_INS_RD, S_INS_WR
  } state_e;

  state_e             state_q, state_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [XW-1:0]      off_q, off_d;
  logic [XW-1:0]      len_q, len_d;
  logic [SIZE_W-1:0]  quo_q, quo_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      jdx_q, jdx_d;
  logic [CW-1:0]      fcnt_q, fcnt_d;
  logic [CW-1:0]      ucnt_q, ucnt_d;
  logic [DW-1:0]      prev_q, prev_d;
  logic [DW-1:0]      next_q, next_d;
  logic               has_next_q, has_next_d;
  logic               e0_q, e0_d;
  logic               rd0_q;
  logic               rvalid_q, rvalid_d;
  status_e            status_q, status_d;
  logic [OFF_W-1:0]   grant_q, grant_d;

  logic               f_we, u_we;
  logic [AW-1:0]      f_waddr, f_raddr, u_waddr, u_raddr;
  logic [DW-1:0]      f_wdata, u_wdata, f_ram, f_rdata, u_rdata;

  logic [XW-1:0]      f_start, f_len, u_start, u_len;
  logic [XW-1:0]      p_start, p_len, n_start, n_len;
  logic [PW-1:0]      prod;
  logic [RS-1:0]      quo_mul;
  logic [XW-1:0]      cut_len;
  logic [CW-1:0]      idx_inc;
  logic               join_prev, join_next;

  ffra_ram #(.AW(AW), .DW(DW)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_ram)
  );

  ffra_ram #(.AW(AW), .DW(DW)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  // free entry 0 reads as the whole page until first written
  assign f_rdata = rd0_q ? {SW'(0), LW'(PAGE_BYTES)} : f_ram;

  // unpack table words
  assign f_start = XW'(f_rdata[LW +: SW]);
  assign f_len   = XW'(f_rdata[LW-1:0]);
  assign u_start = XW'(u_rdata[LW +: SW]);
  assign u_len   = XW'(u_rdata[LW-1:0]);
  assign p_start = XW'(prev_q[LW +: SW]);
  assign p_len   = XW'(prev_q[LW-1:0]);
  assign n_start = XW'(next_q[LW +: SW]);
  assign n_len   = XW'(next_q[LW-1:0]);

  // quotient by grain through a reciprocal multiply, then multiply back
  assign prod      = PW'(size_q) * PW'(RECIP);
  assign quo_mul   = RS'(quo_q) * RS'(GRAIN);
  assign cut_len   = f_len - XW'(size_q);
  assign idx_inc   = idx_q + CW'(1);
  assign join_next = has_next_q && (EW'(off_q) + EW'(len_q) == EW'(n_start));
  assign join_prev = (idx_q != '0) && (EW'(p_start) + EW'(p_len) == EW'(off_q));

  assign req_i.ready        = (state_q == S_IDLE) && !rvalid_q;
  assign rsp_o.valid        = rvalid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.grant_offset = grant_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    size_d     = size_q;
    off_d      = off_q;
    len_d      = len_q;
    quo_d      = quo_q;
    idx_d      = idx_q;
    jdx_d      = jdx_q;
    fcnt_d     = fcnt_q;
    ucnt_d     = ucnt_q;
    prev_d     = prev_q;
    next_d     = next_q;
    has_next_d = has_next_q;
    rvalid_d   = rvalid_q;
    status_d   = status_q;
    grant_d    = grant_q;
    f_we       = 1'b0;
    f_waddr    = idx_q[AW-1:0];
    f_wdata    = f_rdata;
    f_raddr    = idx_q[AW-1:0];
    u_we       = 1'b0;
    u_waddr    = ucnt_q[AW-1:0];
    u_wdata    = u_rdata;
    u_raddr    = idx_q[AW-1:0];

    // drop the response once taken
    if (rvalid_q && rsp_o.ready) begin
      rvalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          size_d   = req_i.req_size;
          off_d    = XW'(req_i.region_offset);
          idx_d    = '0;
          status_d = ST_OK;
          grant_d  = '0;
          if (req_i.cmd == CMD_ALLOC) begin
            state_d = S_MOD;
          end else if (XW'(req_i.region_offset) >= XW'(PAGE_BYTES)) begin
            status_d = ST_BAD_OFFSET;
            rvalid_d = 1'b1;
          end else begin
            state_d = S_U_RD;
          end
        end
      end

      // capture the quotient by grain
      S_MOD: begin
        quo_d   = prod[RS +: SIZE_W];
        state_d = S_CHK;
      end

      S_CHK: begin
        if (size_q == '0 || quo_mul != RS'(size_q)) begin
          status_d = ST_BAD_SIZE;
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else if (ucnt_q >= CW'(MAX_REGIONS)) begin
          status_d = ST_NO_SPACE;
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_A_RD;
        end
      end

      S_A_RD: begin
        if (idx_q >= fcnt_q) begin
          status_d = ST_NO_SPACE;
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_A_CMP;
        end
      end

      // first fit: cut from the top or take the whole region
      S_A_CMP: begin
        if (f_len >= XW'(size_q)) begin
          u_we   = 1'b1;
          ucnt_d = ucnt_q + CW'(1);
          if (f_len > XW'(size_q)) begin
            f_we    = 1'b1;
            f_wdata = {f_rdata[LW +: SW], LW'(cut_len)};
            grant_d = OFF_W'(f_start + cut_len);
            u_wdata = {SW'(f_start + cut_len), LW'(size_q)};
            rvalid_d = 1'b1;
            state_d  = S_IDLE;
          end else begin
            grant_d = OFF_W'(f_start);
            u_wdata = {f_rdata[LW +: SW], LW'(size_q)};
            state_d = S_RM_RD;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = S_A_RD;
        end
      end

      // close the gap at idx by moving entries down
      S_RM_RD: begin
        f_raddr = idx_inc[AW-1:0];
        if (idx_inc >= fcnt_q) begin
          fcnt_d   = fcnt_q - CW'(1);
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_RM_WR;
        end
      end

      S_RM_WR: begin
        f_we    = 1'b1;
        idx_d   = idx_inc;
        state_d = S_RM_RD;
      end

      // look up the allocated region
      S_U_RD: begin
        if (idx_q >= ucnt_q) begin
          status_d = ST_BAD_OFFSET;
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_U_CMP;
        end
      end

      S_U_CMP: begin
        if (u_start == off_q) begin
          len_d   = u_len;
          u_raddr = AW'(ucnt_q - CW'(1));
          state_d = S_U_MV;
        end else begin
          idx_d   = idx_inc;
          state_d = S_U_RD;
        end
      end

      // move the last allocated entry into the hole
      S_U_MV: begin
        u_we       = 1'b1;
        u_waddr    = idx_q[AW-1:0];
        ucnt_d     = ucnt_q - CW'(1);
        idx_d      = '0;
        has_next_d = 1'b0;
        state_d    = S_P_RD;
      end

      // find the first free region above the offset
      S_P_RD: begin
        if (idx_q >= fcnt_q) begin
          state_d = S_JOIN;
        end else begin
          state_d = S_P_CMP;
        end
      end

      S_P_CMP: begin
        if (f_start > off_q) begin
          next_d     = f_rdata;
          has_next_d = 1'b1;
          state_d    = S_JOIN;
        end else begin
          prev_d  = f_rdata;
          idx_d   = idx_inc;
          state_d = S_P_RD;
        end
      end

      // coalesce with neighbors or insert
      S_JOIN: begin
        if (join_prev) begin
          f_we    = 1'b1;
          f_waddr = AW'(idx_q - CW'(1));
          if (join_next) begin
            f_wdata = {prev_q[LW +: SW], LW'(p_len + len_q + n_len)};
            state_d = S_RM_RD;
          end else begin
            f_wdata  = {prev_q[LW +: SW], LW'(p_len + len_q)};
            rvalid_d = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (join_next) begin
          f_we     = 1'b1;
          f_wdata  = {SW'(off_q), LW'(n_len + len_q)};
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else if (fcnt_q < CW'(MAX_REGIONS)) begin
          jdx_d   = fcnt_q;
          state_d = S_INS_RD;
        end else begin
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // open a slot at idx by moving entries up
      S_INS_RD: begin
        f_raddr = AW'(jdx_q - CW'(1));
        if (jdx_q == idx_q) begin
          f_we     = 1'b1;
          f_wdata  = {SW'(off_q), LW'(len_q)};
          fcnt_d   = fcnt_q + CW'(1);
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_INS_WR;
        end
      end

      S_INS_WR: begin
        f_we    = 1'b1;
        f_waddr = jdx_q[AW-1:0];
        jdx_d   = jdx_q - CW'(1);
        state_d = S_INS_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    e0_d = e0_q || (f_we && f_waddr == '0);
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fcnt_q   <= CW'(1);
      ucnt_q   <= '0;
      e0_q     <= 1'b0;
      rd0_q    <= 1'b1;
      rvalid_q <= 1'b0;
      status_q <= ST_OK;
      grant_q  <= '0;
    end else begin
      state_q  <= state_d;
      fcnt_q   <= fcnt_d;
      ucnt_q   <= ucnt_d;
      e0_q     <= e0_d;
      rd0_q    <= (f_raddr == '0) && !e0_d;
      rvalid_q <= rvalid_d;
      status_q <= status_d;
      grant_q  <= grant_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    off_q      <= off_d;
    len_q      <= len_d;
    quo_q      <= quo_d;
    idx_q      <= idx_d;
    jdx_q      <= jdx_d;
    prev_q     <= prev_d;
    next_q     <= next_d;
    has_next_q <= has_next_d;
  end

endmodule

// File: rtl/ffra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ram
// Region table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int AW = 9,
  parameter int DW = 25
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: dv/tb_first_fit_region_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator_core
// Drives allocate and free commands into the region allocator, predicts each
// response with a behavioral copy of the free and allocated tables, and
// compares every response in order. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_first_fit_region_allocator_core;
  import ffra_pkg::*;

  localparam int PAGE  = DEF_PAGE_BYTES;
  localparam int GRAIN = DEF_GRAIN;
  localparam int MAXR  = DEF_MAX_REGIONS;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] grant;
  } rsp_t;

  // Behavioral heap model plus queue of pending responses
  class heap_scoreboard;
    int free_st[$];
    int free_len[$];
    int used_st[$];
    int used_len[$];
    rsp_t pending[$];
    int errors;

    function new();
      free_st = '{0};
      free_len = '{PAGE};
      errors = 0;
    endfunction

    function rsp_t alloc_region(int size);
      rsp_t r;
      int i;
      r.status = ST_OK;
      r.grant = '0;
      if (size == 0 || size % GRAIN != 0) begin
        r.status = ST_BAD_SIZE;
        return r;
      end
      for (i = 0; i < free_st.size(); i++)
        if (free_len[i] >= size) break;
      if (i >= free_st.size() || used_st.size() >= MAXR) begin
        r.status = ST_NO_SPACE;
        return r;
      end
      if (free_len[i] > size) begin
        free_len[i] -= size;
        r.grant = free_st[i] + free_len[i];
      end else begin
        r.grant = free_st[i];
        free_st.delete(i);
        free_len.delete(i);
      end
      used_st.push_back(r.grant);
      used_len.push_back(size);
      return r;
    endfunction

    function rsp_t free_region(int off);
      rsp_t r;
      int u, len, i, last;
      bit jp, jn;
      r.status = ST_BAD_OFFSET;
      r.grant = '0;
      if (off >= PAGE) return r;
      for (u = 0; u < used_st.size(); u++)
        if (used_st[u] == off) break;
      if (u >= used_st.size()) return r;
      r.status = ST_OK;
      len = used_len[u];
      last = used_st.size() - 1;
      used_st[u] = used_st[last];
      used_len[u] = used_len[last];
      used_st.pop_back();
      used_len.pop_back();
      for (i = 0; i < free_st.size(); i++)
        if (free_st[i] > off) break;
      jn = (i < free_st.size()) && (off + len == free_st[i]);
      jp = (i > 0) && (free_st[i-1] + free_len[i-1] == off);
      if (jp && jn) begin
        free_len[i-1] += len + free_len[i];
        free_st.delete(i);
        free_len.delete(i);
      end else if (jp) begin
        free_len[i-1] += len;
      end else if (jn) begin
        free_st[i] = off;
        free_len[i] += len;
      end else if (free_st.size() < MAXR) begin
        free_st.insert(i, off);
        free_len.insert(i, len);
      end
      return r;
    endfunction

    function void note_command(cmd_e c, int size, int off);
      pending.push_back(c == CMD_ALLOC ? alloc_region(size) : free_region(off));
    endfunction

    function void check_response(status_e st, logic [OFF_W-1:0] g);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response expected none actual status=%0d grant=%0d",
                 $time, st, g);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (g !== e.grant) begin
        $display("%0t: grant mismatch expected %0d actual %0d", $time, e.grant, g);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  ffra_cmd_if req_if();
  ffra_rsp_if rsp_if();
  heap_scoreboard sb = new();

  bit quiet = 1'b0;
  int hold_off = 0;
  int rx_idle = 0;
  int idle_cycles = 0;

  first_fit_region_allocator_core uut (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.cmd = CMD_ALLOC;
    req_if.req_size = '0;
    req_if.region_offset = '0;
    rsp_if.ready = 1'b0;
  end

  // Receiver: random idle bursts, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.status, rsp_if.grant_offset);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp_if.ready <= 1'b0;
      end else if (quiet) begin
        rsp_if.ready <= 1'b1;
      end else if (rx_idle > 0) begin
        rx_idle <= rx_idle - 1;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        rx_idle <= $urandom_range(0, 13);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("first_fit_region_allocator_core test failed");
      $finish;
    end
  end

  // Send one command and wait for its transaction
  task automatic send_cmd(cmd_e c, int size, int off);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= c;
    req_if.req_size <= size[SIZE_W-1:0];
    req_if.region_offset <= off[OFF_W-1:0];
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_command(c, size, off);
  endtask

  // Pick a live allocated offset or a random one
  function automatic int pick_offset();
    if (sb.used_st.size() > 0 && $urandom_range(0, 9) != 0)
      return sb.used_st[$urandom_range(0, sb.used_st.size() - 1)];
    return $urandom_range(0, 4095);
  endfunction

  function automatic int pick_size();
    int k = $urandom_range(0, 19);
    if (k == 0) return $urandom_range(0, 8191);
    if (k == 1) return $urandom_range(0, 4096);
    if (k < 4) return GRAIN * $urandom_range(32, 512);
    return GRAIN * $urandom_range(1, 16);
  endfunction

  initial begin
    int n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: size extremes, exact fit, no space, merges, bad offsets
    send_cmd(CMD_ALLOC, 0, 0);
    send_cmd(CMD_ALLOC, 13'h1fff, 12'hfff);
    send_cmd(CMD_ALLOC, 7, 0);
    send_cmd(CMD_ALLOC, 4104, 0);
    send_cmd(CMD_ALLOC, 4096, 0);
    send_cmd(CMD_ALLOC, 8, 0);
    send_cmd(CMD_FREE, 0, 0);
    send_cmd(CMD_FREE, 0, 0);
    send_cmd(CMD_ALLOC, 1024, 0);
    send_cmd(CMD_ALLOC, 1024, 0);
    send_cmd(CMD_ALLOC, 1024, 0);
    send_cmd(CMD_FREE, 0, 2048);
    send_cmd(CMD_FREE, 0, 3072);
    send_cmd(CMD_FREE, 0, 4095);
    send_cmd(CMD_FREE, 0, 100);
    send_cmd(CMD_ALLOC, 8, 0);
    send_cmd(CMD_ALLOC, 8, 0);
    send_cmd(CMD_ALLOC, 8, 0);
    send_cmd(CMD_FREE, 0, 3064);
    send_cmd(CMD_FREE, 0, 3048);
    send_cmd(CMD_FREE, 0, 3056);
    send_cmd(CMD_FREE, 0, 3072);

    // Fill the receiver side: long hold-off while commands keep coming
    hold_off = 400;
    for (n = 0; n < 20; n++) send_cmd(CMD_ALLOC, GRAIN * $urandom_range(1, 4), 0);

    // Random mix, alternating between alloc-biased and free-biased phases
    for (n = 0; n < 930; n++) begin
      if (n > 800) quiet = 1'b1;
      if ($urandom_range(0, 99) < ((n / 150) % 2 == 0 ? 65 : 35))
        send_cmd(CMD_ALLOC, pick_size(), $urandom_range(0, 4095));
      else
        send_cmd(CMD_FREE, $urandom_range(0, 8191), pick_offset());
    end
    req_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0)
      $display("first_fit_region_allocator_core test passed");
    else
      $display("first_fit_region_allocator_core test failed");
    $finish;
  end
endmodule
